// File: rtl/sact_pkg.sv
// sact_pkg: geometry constants and shared types of the cache tag controller
// no dependencies
`default_nettype none
package sact_pkg;
  localparam int NUM_SETS    = 64;
  localparam int NUM_WAYS    = 4;
  localparam int LINE_BYTES  = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int OFF_BITS    = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int TAG_BITS    = 64 - OFF_BITS - SET_BITS;
  localparam int WAY_BITS    = $clog2(NUM_WAYS);
  localparam int QDEPTH      = 2;

  localparam logic [1:0] POL_PLRU   = 2'd0;
  localparam logic [1:0] POL_LFU    = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic                cmd;
    logic [TAG_BITS-1:0] tag;
    logic [SET_BITS-1:0] set;
  } req_t;

  typedef struct packed {
    logic          hit;
    logic [1:0]    way;
    logic          fetch_request;
    logic          writeback_valid;
    logic [63:0]   writeback_address;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/sact_front.sv
// sact_front: accepts accesses, splits address into tag and set, queues them
// depends on sact_pkg
`default_nettype none
module sact_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_push,
  output logic              in_full,
  input  wire               in_cmd,
  input  wire  [63:0]       in_address,
  output logic              q_valid,
  output sact_pkg::req_t    q_req,
  input  wire               q_take
);
  import sact_pkg::*;
  req_t q_r [QDEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_push;

  assign in_full = (cnt_r == 2'(QDEPTH));
  assign do_push = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r].cmd <= in_cmd;
      q_r[wp_r].set <= in_address[OFF_BITS +: SET_BITS];
      q_r[wp_r].tag <= in_address[63 -: TAG_BITS];
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (q_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(do_push) - 2'(q_take);
    end
  end
endmodule
`default_nettype wire

// File: rtl/sact_back.sv
// sact_back: reads a set, resolves hit or victim, writes the set back
// depends on sact_pkg
`default_nettype none
module sact_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire  [1:0]        policy,
  input  wire               q_valid,
  input  sact_pkg::req_t    q_req,
  output logic              q_take,
  output logic              out_empty,
  input  wire               out_pop,
  output sact_pkg::res_t    res
);
  import sact_pkg::*;
  typedef enum logic [2:0] {S_CLR = 3'b001, S_READ = 3'b010, S_UPD = 3'b100} st_t;

  // per-set marks and use counts, one row per set
  typedef struct packed {
    logic [NUM_WAYS-1:0]                  mru;
    logic [NUM_WAYS-1:0]                  dirty;
    logic [NUM_WAYS-1:0]                  valid;
    logic [NUM_WAYS-1:0][COUNT_WIDTH-1:0] cnt;
  } meta_t;

  logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_mem [NUM_SETS];
  meta_t meta_mem [NUM_SETS];
  logic [15:0] lfsr_r, lfsr_nxt;
  st_t st_r;
  logic [SET_BITS-1:0] clr_r;
  req_t cur_r;
  logic [NUM_WAYS-1:0][TAG_BITS-1:0] rtag_r;
  meta_t rmeta_r;
  logic res_full_r;
  res_t res_r;

  logic [NUM_WAYS-1:0] v_s, d_s, m_s, m_new;
  logic found;
  logic [WAY_BITS-1:0] hw, vw, w;
  logic plru_found;
  logic [WAY_BITS-1:0] pw, lw;
  logic [COUNT_WIDTH-1:0] best;
  logic wb_s;
  meta_t meta_new;
  logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_new;
  logic can_upd;

  assign can_upd = (st_r == S_UPD) && (!res_full_r || out_pop);
  assign q_take = q_valid && (st_r == S_READ);
  assign out_empty = !res_full_r;
  assign res = res_r;

  always_comb begin
    v_s = rmeta_r.valid;
    d_s = rmeta_r.dirty;
    m_s = rmeta_r.mru;
    found = 1'b0; hw = '0;
    for (int i = NUM_WAYS-1; i >= 0; i--)
      if (v_s[i] && rtag_r[i] == cur_r.tag) begin
        found = 1'b1; hw = WAY_BITS'(i);
      end
    plru_found = 1'b0; pw = '0;
    for (int i = NUM_WAYS-1; i >= 0; i--)
      if (!m_s[i]) begin
        plru_found = 1'b1; pw = WAY_BITS'(i);
      end
    best = rmeta_r.cnt[0]; lw = '0;
    for (int i = 1; i < NUM_WAYS; i++)
      if (rmeta_r.cnt[i] < best) begin
        best = rmeta_r.cnt[i]; lw = WAY_BITS'(i);
      end
    // galois step, taken only on a random miss
    lfsr_nxt = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_MASK : 16'h0);
    case (policy)
      POL_LFU:    vw = lw;
      POL_RANDOM: vw = lfsr_nxt[WAY_BITS-1:0];
      default:    vw = pw;
    endcase
    w = found ? hw : vw;
    m_new = m_s;
    m_new[w] = 1'b1;
    if (&m_new) begin
      m_new = '0;
      m_new[w] = 1'b1;
    end
    wb_s = !found && v_s[vw] && d_s[vw];
    meta_new = rmeta_r;
    meta_new.mru = m_new;
    meta_new.valid[w] = 1'b1;
    meta_new.dirty[w] = found ? (d_s[w] | cur_r.cmd) : cur_r.cmd;
    tag_new = rtag_r;
    if (found) begin
      if (rmeta_r.cnt[hw] != {COUNT_WIDTH{1'b1}})
        meta_new.cnt[hw] = rmeta_r.cnt[hw] + COUNT_WIDTH'(1);
    end else begin
      meta_new.cnt[vw] = COUNT_WIDTH'(1);
      tag_new[vw] = cur_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_r <= q_req;
      rtag_r <= tag_mem[q_req.set];
      rmeta_r <= meta_mem[q_req.set];
    end
    // clearing pass after reset, one set per cycle
    if (st_r == S_CLR) meta_mem[clr_r] <= '0;
    if (can_upd) begin
      res_r.hit <= found;
      res_r.way <= 2'(w);
      res_r.fetch_request <= !found;
      res_r.writeback_valid <= wb_s;
      res_r.writeback_address <= wb_s ? {rtag_r[vw], cur_r.set, {OFF_BITS{1'b0}}} : 64'd0;
      tag_mem[cur_r.set] <= tag_new;
      meta_mem[cur_r.set] <= meta_new;
    end
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0;
      lfsr_r <= LFSR_SEED; res_full_r <= 1'b0;
    end else begin
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) st_r <= S_READ;
        end
        S_READ: if (q_valid) st_r <= S_UPD;
        S_UPD:  if (can_upd) st_r <= S_READ;
        default: st_r <= S_CLR;
      endcase
      if (out_pop && res_full_r) res_full_r <= 1'b0;
      if (can_upd) begin
        res_full_r <= 1'b1;
        if (!found && policy == POL_RANDOM) lfsr_r <= lfsr_nxt;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/set_assoc_cache_tag_controller.sv
// set_assoc_cache_tag_controller: top level, front queue plus back engine
// the back engine captures the set in its read registers when it takes an access, then
// writes the set back and registers the result; the result register waits for pop,
// and the back engine takes no new access before it is done with the last one
// reset: synchronous active-low; then a pass over all sets clears marks and counts,
// accesses queue up meanwhile; depends on sact_pkg, sact_front, sact_back
`default_nettype none
module set_assoc_cache_tag_controller (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        full,
  input  wire         in_cmd,
  input  wire  [63:0] in_address,
  output logic        empty,
  input  wire         pop,
  output logic        out_hit,
  output logic [1:0]  out_way,
  output logic        out_fetch_request,
  output logic        out_writeback_valid,
  output logic [63:0] out_writeback_address,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_replacement_policy
);
  import sact_pkg::*;
  logic [1:0] pol_r;
  logic q_valid, q_take;
  req_t q_req;
  res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) pol_r <= POL_PLRU;
    else if (cfg_valid) pol_r <= cfg_replacement_policy;
  end

  sact_front u_front (.clk, .rst_n, .in_push, .in_full(full), .in_cmd, .in_address,
    .q_valid, .q_req, .q_take);
  sact_back u_back (.clk, .rst_n, .policy(pol_r), .q_valid, .q_req, .q_take,
    .out_empty(empty), .out_pop(pop), .res);

  assign out_hit = res.hit;
  assign out_way = res.way;
  assign out_fetch_request = res.fetch_request;
  assign out_writeback_valid = res.writeback_valid;
  assign out_writeback_address = res.writeback_address;
endmodule
`default_nettype wire

// File: rtl/sact_checker.sv
// sact_checker: port-level checks of the tag controller
// bound to set_assoc_cache_tag_controller
`default_nettype none
module sact_checker (
  input wire clk, input wire rst_n, input wire empty, input wire pop,
  input wire out_hit, input wire out_fetch_request, input wire out_writeback_valid,
  input wire [63:0] out_writeback_address
);
  a_hit_xor: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_hit != out_fetch_request)) else $error("hit and fetch both");
  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_writeback_valid) |-> out_fetch_request) else $error("wb on hit");
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_writeback_valid) |-> out_writeback_address == 64'd0)
    else $error("stray wb address");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty) else $error("beat dropped");
endmodule
bind set_assoc_cache_tag_controller sact_checker u_chk (.clk, .rst_n, .empty, .pop,
  .out_hit, .out_fetch_request, .out_writeback_valid, .out_writeback_address);
`default_nettype wire

// File: dv/set_assoc_cache_tag_controller_tb.sv
// testbench for set_assoc_cache_tag_controller: predicts hit, way, fetch and writeback
// per access from a behavioural copy of the tag, mark and count state; depends on sact_pkg
`timescale 1ns / 100ps
`default_nettype none

class cache_access_scoreboard;
  logic [1:0]  policy;
  logic [63:0] tags   [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
  bit          valid  [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
  bit          dirty  [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
  bit          mru    [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
  int unsigned counts [sact_pkg::NUM_SETS][sact_pkg::NUM_WAYS];
  logic [15:0] lfsr;
  sact_pkg::res_t pending[$];
  int errors;
  int checked;
  int hits;
  int writebacks;

  function new();
    policy = sact_pkg::POL_PLRU;
    lfsr = sact_pkg::LFSR_SEED;
    errors = 0;
    checked = 0;
    hits = 0;
    writebacks = 0;
    foreach (valid[s, w]) begin
      valid[s][w] = 0;
      dirty[s][w] = 0;
      mru[s][w] = 0;
      counts[s][w] = 0;
      tags[s][w] = '0;
    end
  endfunction

  function void touch(int s, int w);
    bit all;
    all = 1;
    mru[s][w] = 1;
    for (int i = 0; i < sact_pkg::NUM_WAYS; i++) if (!mru[s][i]) all = 0;
    if (all) for (int i = 0; i < sact_pkg::NUM_WAYS; i++) mru[s][i] = (i == w);
  endfunction

  function int victim(int s);
    int v;
    v = 0;
    if (policy == sact_pkg::POL_LFU) begin
      for (int i = 1; i < sact_pkg::NUM_WAYS; i++) if (counts[s][i] < counts[s][v]) v = i;
      return v;
    end
    if (policy == sact_pkg::POL_RANDOM) begin
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ sact_pkg::LFSR_MASK) : (lfsr >> 1);
      return lfsr % sact_pkg::NUM_WAYS;
    end
    for (int i = 0; i < sact_pkg::NUM_WAYS; i++) if (!mru[s][i]) return i;
    return 0;
  endfunction

  function void note_access(logic is_write, logic [63:0] addr);
    sact_pkg::res_t r;
    int s;
    int w;
    logic [63:0] tag;
    s = (addr >> sact_pkg::OFF_BITS) % sact_pkg::NUM_SETS;
    tag = addr >> (sact_pkg::OFF_BITS + sact_pkg::SET_BITS);
    r = '0;
    w = -1;
    for (int i = 0; i < sact_pkg::NUM_WAYS; i++)
      if (w < 0 && valid[s][i] && tags[s][i] == tag) w = i;
    if (w >= 0) begin
      r.hit = 1;
      if (is_write) dirty[s][w] = 1;
      touch(s, w);
      if (counts[s][w] < (1 << sact_pkg::COUNT_WIDTH) - 1) counts[s][w]++;
    end else begin
      w = victim(s);
      r.fetch_request = 1;
      if (valid[s][w] && dirty[s][w]) begin
        r.writeback_valid = 1;
        r.writeback_address = (tags[s][w] << (sact_pkg::OFF_BITS + sact_pkg::SET_BITS))
                            | (64'(s) << sact_pkg::OFF_BITS);
      end
      tags[s][w] = tag;
      valid[s][w] = 1;
      dirty[s][w] = is_write;
      counts[s][w] = 1;
      touch(s, w);
    end
    r.way = w[1:0];
    pending.push_back(r);
  endfunction

  function void check_result(sact_pkg::res_t got);
    sact_pkg::res_t exp;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result with nothing expected: %p", got);
      return;
    end
    exp = pending.pop_front();
    hits += exp.hit;
    writebacks += exp.writeback_valid;
    if (got !== exp) begin
      errors++;
      if (errors <= 10) $display("mismatch at result %0d: expected %p, got %p", checked, exp, got);
    end
  endfunction
endclass

module set_assoc_cache_tag_controller_tb;
  import sact_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_cmd = 0;
  logic [63:0] in_address = '0;
  logic pop = 0;
  logic cfg_valid = 0;
  logic [1:0] cfg_replacement_policy = POL_PLRU;
  wire full, empty, cfg_ready;
  wire out_hit, out_fetch_request, out_writeback_valid;
  wire [1:0] out_way;
  wire [63:0] out_writeback_address;

  cache_access_scoreboard model = new();
  int sent;
  bit stim_done;
  logic [63:0] hot_tags[8];

  set_assoc_cache_tag_controller u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .full(full), .in_cmd(in_cmd), .in_address(in_address),
    .empty(empty), .pop(pop),
    .out_hit(out_hit), .out_way(out_way), .out_fetch_request(out_fetch_request),
    .out_writeback_valid(out_writeback_valid), .out_writeback_address(out_writeback_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_replacement_policy(cfg_replacement_policy)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic write_policy(logic [1:0] p);
    cfg_valid <= 1;
    cfg_replacement_policy <= p;
    do @(posedge clk); while (!cfg_ready);
    model.policy = p;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // drives one beat; a random idle gap is drawn per item unless burst
  task automatic send_access(logic is_write, logic [63:0] addr, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1;
    in_cmd <= is_write;
    in_address <= addr;
    do @(posedge clk); while (full);
    model.note_access(is_write, addr);
    sent++;
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_push <= 0;
    while (model.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // same set, small pool of tags, so hits, evictions and writebacks all occur
  function automatic logic [63:0] pooled_addr(int s);
    logic [63:0] t;
    t = hot_tags[$urandom_range(0, 5)];
    return (t << (OFF_BITS + SET_BITS)) | (64'(s) << OFF_BITS) | 64'($urandom_range(0, 63));
  endfunction

  task automatic random_phase(int n);
    int s;
    bit burst;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
      if (i % 25 == 0) s = $urandom_range(0, NUM_SETS - 1);
      if ($urandom_range(0, 9) == 0)
        send_access($urandom_range(0, 1), {$urandom, $urandom}, burst);
      else
        send_access($urandom_range(0, 1), pooled_addr($urandom_range(0, 3) == 0 ?
                    $urandom_range(0, NUM_SETS - 1) : s), burst);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    hot_tags[0] = '0;
    hot_tags[1] = {TAG_BITS{1'b1}};
    for (int i = 2; i < 8; i++) hot_tags[i] = {$urandom, $urandom};

    // directed: extremes, read/write hits, fill a set, dirty eviction
    send_access(0, 64'h0, 1);
    send_access(1, 64'h0, 1);
    send_access(1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_access(0, 64'hFFFF_FFFF_FFFF_FFC0, 1);
    for (int i = 1; i <= 5; i++) send_access(1, 64'(i) << (OFF_BITS + SET_BITS), 0);
    send_access(0, 64'h0, 0);
    send_access(0, 64'hAAAA_AAAA_AAAA_AAAA, 1);
    send_access(1, 64'h5555_5555_5555_5555, 1);
    quiesce();

    write_policy(POL_LFU);
    for (int i = 0; i < 6; i++) send_access(i[0], 64'(i % 3) << (OFF_BITS + SET_BITS), 1);
    quiesce();
    write_policy(POL_RANDOM);
    for (int i = 0; i < 6; i++) send_access(1, 64'(i + 9) << (OFF_BITS + SET_BITS), 1);
    quiesce();
    write_policy(2'd3);
    for (int i = 0; i < 4; i++) send_access(0, 64'(i + 20) << (OFF_BITS + SET_BITS), 1);
    quiesce();

    for (int ph = 0; ph < 4; ph++) begin
      write_policy(ph == 3 ? POL_PLRU : ph[1:0]);
      random_phase(250);
      quiesce();
    end
    stim_done = 1;
  end

  // result side: a random idle gap per beat, then pop until taken
  initial begin
    sact_pkg::res_t r;
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 16);
      pop <= 1'b0;
      repeat (gap) @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (!(rst_n && !empty));
      r.hit = out_hit;
      r.way = out_way;
      r.fetch_request = out_fetch_request;
      r.writeback_valid = out_writeback_valid;
      r.writeback_address = out_writeback_address;
      model.check_result(r);
      @(negedge clk);
    end
  end

  initial begin
    wait (stim_done);
    repeat (20) @(posedge clk);
    if (model.pending.size() != 0) begin
      model.errors++;
      $display("%0d expected results never arrived", model.pending.size());
    end
    $display("%0d accesses under all four policy codes, %0d hits, %0d writebacks, %0d errors",
             sent, model.hits, model.writebacks, model.errors);
    if (model.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout after %0d accesses", sent);
    $display("*** FAILED ***");
    $finish;
  end
endmodule

`default_nettype wire
